// ===== hw/rtl/mtocc_pkg.sv =====
// Shared types and constants for the mask tile occupancy core.
// Used by every module in hw/rtl except mtocc_ram; depends on nothing.
package mtocc_pkg;

  localparam int MASK_W      = 8;
  localparam int IMG_W       = 13;
  localparam int POS_W       = 12;
  localparam int TCFG_W      = 7;
  localparam int RIT_W       = 6;
  localparam int CIT_W       = 6;
  localparam int TC_W        = 8;
  localparam int CNT_W       = 13;
  localparam int AREA_W      = 13;
  localparam int NUM_W       = 20;
  localparam int IDX_W       = 20;
  localparam int PCT_W       = 7;
  localparam int XC_W        = 9;
  localparam int STEP_W      = 5;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int OUT_TDATA_W = 32;
  localparam int TC_LIMIT    = 256;

  localparam logic [IMG_W-1:0]  MAX_IMAGE_SIDE = 13'd4096;
  localparam logic [TCFG_W-1:0] MAX_TILE_SIDE  = 7'd64;
  localparam logic [TCFG_W-1:0] MIN_TILE_W     = 7'd16;
  localparam logic [CNT_W-1:0]  COUNT_MAX      = 13'd8191;
  localparam logic [PCT_W-1:0]  PERCENT_SCALE  = 7'd100;

  localparam logic [IMG_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [IMG_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [TCFG_W-1:0] RST_TILE_WIDTH   = 7'd32;
  localparam logic [TCFG_W-1:0] RST_TILE_HEIGHT  = 7'd32;

  localparam logic [STEP_W-1:0] TC_STEPS  = 5'd12;
  localparam logic [STEP_W-1:0] PCT_STEPS = 5'd7;
  localparam logic [STEP_W-1:0] XC_STEPS  = 5'd13;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TILE_WIDTH   = 2'd2,
    REG_TILE_HEIGHT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_TC  = 2'd0,
    DIV_PCT = 2'd1,
    DIV_XC  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     latch_tc;
    logic     latch_cnt;
    logic     mul;
    logic     latch_pct;
    logic     latch_xc;
    logic     calc_idx;
    logic     commit;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic tile_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/mtocc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtocc_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mtocc_div.sv =====
// Shift-subtract restoring divider, one quotient bit per cycle.
// Depends on mtocc_pkg for widths.
module mtocc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mtocc_pkg::STEP_W-1:0]      steps,
  input  logic [mtocc_pkg::AREA_W-1:0]      rem_init,
  input  logic [mtocc_pkg::NUM_W-1:0]       dividend,
  input  logic [mtocc_pkg::AREA_W-1:0]      divisor,
  output logic [mtocc_pkg::NUM_W-1:0]       quo,
  output logic [mtocc_pkg::AREA_W-1:0]      rem,
  output logic                              done
);

  logic                            busy_r;
  logic                            done_r;
  logic [mtocc_pkg::STEP_W-1:0]    cnt_r;
  logic [mtocc_pkg::AREA_W-1:0]    rem_r;
  logic [mtocc_pkg::NUM_W-1:0]     dvd_r;
  logic [mtocc_pkg::NUM_W-1:0]     quo_r;
  logic [mtocc_pkg::AREA_W-1:0]    div_r;
  logic [mtocc_pkg::AREA_W:0]      shifted;
  logic [mtocc_pkg::AREA_W:0]      diff;
  logic                            take;

  assign shifted = {rem_r, dvd_r[mtocc_pkg::NUM_W-1]};
  assign take    = shifted >= {1'b0, div_r};
  assign diff    = shifted - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvd_r <= dividend;
      quo_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[mtocc_pkg::AREA_W-1:0] : shifted[mtocc_pkg::AREA_W-1:0];
      dvd_r <= {dvd_r[mtocc_pkg::NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[mtocc_pkg::NUM_W-2:0], take};
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ===== hw/rtl/mtocc_dp.sv =====
// Datapath: configuration registers, frame position tracking, per-column
// count RAM, divider operand selection and the output word register.
// Depends on mtocc_pkg, mtocc_ram and mtocc_div.
module mtocc_dp #(
  parameter int MAX_TILE_COLUMNS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mtocc_pkg::ctrl_cmd_t                 cmd,
  output mtocc_pkg::dp_status_t                status,
  input  logic [mtocc_pkg::MASK_W-1:0]         in_tdata,
  input  logic                                 cfg_we,
  input  logic [mtocc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mtocc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mtocc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tlast
);

  localparam int DEPTH  = (MAX_TILE_COLUMNS < mtocc_pkg::TC_LIMIT) ?
                          MAX_TILE_COLUMNS : mtocc_pkg::TC_LIMIT;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [mtocc_pkg::IMG_W-1:0]  img_w_r, img_h_r;
  logic [mtocc_pkg::TCFG_W-1:0] tile_w_r, tile_h_r;

  // frame position
  logic [mtocc_pkg::POS_W-1:0]  col_r, row_r, trn_r;
  logic [mtocc_pkg::RIT_W-1:0]  rit_r;

  // per-word working registers
  logic [mtocc_pkg::IMG_W-1:0]  w_r;
  logic [mtocc_pkg::TCFG_W-1:0] tw_r, th_r;
  logic [mtocc_pkg::POS_W-1:0]  x_r, y_r;
  logic [mtocc_pkg::RIT_W-1:0]  rite_r;
  logic                         set_r, row_last_r, flr_r, tre_r, tile_done_r;
  logic [mtocc_pkg::TC_W-1:0]   tc_r;
  logic [mtocc_pkg::CIT_W-1:0]  cit_r;
  logic [mtocc_pkg::CNT_W-1:0]  cnt_r;
  logic [mtocc_pkg::AREA_W-1:0] area_r;
  logic [mtocc_pkg::NUM_W-1:0]  numer_r;
  logic [mtocc_pkg::PCT_W-1:0]  pct_r;
  logic [mtocc_pkg::XC_W-1:0]   xc_r;
  logic [mtocc_pkg::IDX_W-1:0]  idx_r;
  logic [DEPTH-1:0]             valid_r;

  // output word
  logic                         out_valid_r;
  logic [mtocc_pkg::IDX_W-1:0]  out_idx_r;
  logic [mtocc_pkg::PCT_W-1:0]  out_pct_r;
  logic                         out_last_r;

  // combinational
  logic [mtocc_pkg::IMG_W-1:0]  w_eff, h_eff, w_m1, h_m1, wsum;
  logic [mtocc_pkg::TCFG_W-1:0] tw_eff, th_eff, th_m1;
  logic [mtocc_pkg::POS_W-1:0]  x_sel, y_sel;
  logic [mtocc_pkg::RIT_W-1:0]  rite_sel;
  logic                         row_last_sel, flr_sel;
  logic [SLOT_W-1:0]            slot;
  logic [mtocc_pkg::CNT_W-1:0]  ram_rdata, cur_cnt, ram_wdata;
  logic [mtocc_pkg::TCFG_W-1:0] cit_p1, rit_p1;
  logic [mtocc_pkg::AREA_W:0]   area_full;
  logic [mtocc_pkg::NUM_W-1:0]  numer_full;
  logic [mtocc_pkg::IDX_W+1:0]  idx_full;
  logic                         pct_sat;
  logic [mtocc_pkg::PCT_W-1:0]  pct_q;

  logic [mtocc_pkg::STEP_W-1:0] div_steps;
  logic [mtocc_pkg::AREA_W-1:0] div_rem_init, div_divisor, div_rem;
  logic [mtocc_pkg::NUM_W-1:0]  div_dividend, div_quo;
  logic                         div_done;

  // geometry clamps
  always_comb begin
    priority if (img_w_r == '0)                         w_eff = 13'd1;
    else if (img_w_r > mtocc_pkg::MAX_IMAGE_SIDE)       w_eff = mtocc_pkg::MAX_IMAGE_SIDE;
    else                                                w_eff = img_w_r;
    priority if (img_h_r == '0)                         h_eff = 13'd1;
    else if (img_h_r > mtocc_pkg::MAX_IMAGE_SIDE)       h_eff = mtocc_pkg::MAX_IMAGE_SIDE;
    else                                                h_eff = img_h_r;
    priority if (tile_w_r < mtocc_pkg::MIN_TILE_W)      tw_eff = mtocc_pkg::MIN_TILE_W;
    else if (tile_w_r > mtocc_pkg::MAX_TILE_SIDE)       tw_eff = mtocc_pkg::MAX_TILE_SIDE;
    else                                                tw_eff = tile_w_r;
    priority if (tile_h_r == '0)                        th_eff = 7'd1;
    else if (tile_h_r > mtocc_pkg::MAX_TILE_SIDE)       th_eff = mtocc_pkg::MAX_TILE_SIDE;
    else                                                th_eff = tile_h_r;
  end

  assign w_m1     = w_eff - 13'd1;
  assign h_m1     = h_eff - 13'd1;
  assign th_m1    = th_eff - 7'd1;
  assign x_sel    = ({1'b0, col_r} < w_eff) ? col_r : w_m1[mtocc_pkg::POS_W-1:0];
  assign y_sel    = ({1'b0, row_r} < h_eff) ? row_r : h_m1[mtocc_pkg::POS_W-1:0];
  assign rite_sel = ({1'b0, rit_r} < th_eff) ? rit_r : th_m1[mtocc_pkg::RIT_W-1:0];
  assign row_last_sel = ({1'b0, x_sel} == w_m1);
  assign flr_sel      = ({1'b0, y_sel} == h_m1);

  assign wsum = w_r + {6'd0, tw_r} - 13'd1;

  // counter slot, last slot shared by columns beyond the RAM
  assign slot = ({1'b0, tc_r} < 9'(DEPTH)) ? SLOT_W'(tc_r) : SLOT_W'(DEPTH - 1);

  assign cur_cnt   = valid_r[slot] ? ram_rdata : '0;
  assign ram_wdata = tile_done_r ? '0 : cnt_r;

  assign cit_p1     = {1'b0, cit_r} + 7'd1;
  assign rit_p1     = {1'b0, rite_r} + 7'd1;
  assign area_full  = 14'(cit_p1) * 14'(rit_p1);
  assign numer_full = 20'(cnt_r) * 20'(mtocc_pkg::PERCENT_SCALE);
  assign idx_full   = 22'(trn_r) * 22'(xc_r) + 22'(tc_r);

  assign pct_sat = numer_r >= {area_r, 7'd0};
  assign pct_q   = div_quo[mtocc_pkg::PCT_W-1:0];

  always_comb begin
    unique case (cmd.div_sel)
      mtocc_pkg::DIV_TC: begin
        div_steps    = mtocc_pkg::TC_STEPS;
        div_rem_init = '0;
        div_dividend = {x_r, 8'd0};
        div_divisor  = {6'd0, tw_r};
      end
      mtocc_pkg::DIV_PCT: begin
        div_steps    = mtocc_pkg::PCT_STEPS;
        div_rem_init = numer_r[mtocc_pkg::NUM_W-1:7];
        div_dividend = {numer_r[6:0], 13'd0};
        div_divisor  = area_r;
      end
      mtocc_pkg::DIV_XC: begin
        div_steps    = mtocc_pkg::XC_STEPS;
        div_rem_init = '0;
        div_dividend = {wsum, 7'd0};
        div_divisor  = {6'd0, tw_r};
      end
      default: begin
        div_steps    = mtocc_pkg::TC_STEPS;
        div_rem_init = '0;
        div_dividend = '0;
        div_divisor  = {6'd0, tw_r};
      end
    endcase
  end

  mtocc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .steps    (div_steps),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quo      (div_quo),
    .rem      (div_rem),
    .done     (div_done)
  );

  mtocc_ram #(
    .WIDTH (mtocc_pkg::CNT_W),
    .DEPTH (DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r     <= mtocc_pkg::RST_IMAGE_WIDTH;
      img_h_r     <= mtocc_pkg::RST_IMAGE_HEIGHT;
      tile_w_r    <= mtocc_pkg::RST_TILE_WIDTH;
      tile_h_r    <= mtocc_pkg::RST_TILE_HEIGHT;
      col_r       <= '0;
      row_r       <= '0;
      rit_r       <= '0;
      trn_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (mtocc_pkg::cfg_reg_t'(cfg_addr))
          mtocc_pkg::REG_IMAGE_WIDTH:  img_w_r  <= cfg_wdata;
          mtocc_pkg::REG_IMAGE_HEIGHT: img_h_r  <= cfg_wdata;
          mtocc_pkg::REG_TILE_WIDTH:   tile_w_r <= cfg_wdata[mtocc_pkg::TCFG_W-1:0];
          mtocc_pkg::REG_TILE_HEIGHT:  tile_h_r <= cfg_wdata[mtocc_pkg::TCFG_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        valid_r[slot] <= 1'b1;
        if (row_last_r) begin
          col_r <= '0;
          if (flr_r) begin
            row_r <= '0;
            rit_r <= '0;
            trn_r <= '0;
          end else begin
            row_r <= y_r + 12'd1;
            if ({1'b0, rite_r} == th_r - 7'd1) begin
              rit_r <= '0;
              trn_r <= trn_r + 12'd1;
            end else begin
              rit_r <= rite_r + 6'd1;
            end
          end
        end else begin
          col_r <= x_r + 12'd1;
          row_r <= y_r;
          rit_r <= rite_r;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r        <= w_eff;
      tw_r       <= tw_eff;
      th_r       <= th_eff;
      x_r        <= x_sel;
      y_r        <= y_sel;
      rite_r     <= rite_sel;
      set_r      <= |in_tdata;
      row_last_r <= row_last_sel;
      flr_r      <= flr_sel;
      tre_r      <= ({1'b0, rite_sel} == th_m1) || flr_sel;
    end
    if (cmd.latch_tc) begin
      tc_r        <= div_quo[mtocc_pkg::TC_W-1:0];
      cit_r       <= div_rem[mtocc_pkg::CIT_W-1:0];
      tile_done_r <= (({1'b0, div_rem[mtocc_pkg::CIT_W-1:0]} == tw_r - 7'd1) || row_last_r)
                     && tre_r;
    end
    if (cmd.latch_cnt) begin
      cnt_r <= (set_r && cur_cnt != mtocc_pkg::COUNT_MAX) ? cur_cnt + 13'd1 : cur_cnt;
    end
    if (cmd.mul) begin
      area_r  <= area_full[mtocc_pkg::AREA_W-1:0];
      numer_r <= numer_full;
    end
    if (cmd.latch_pct) begin
      pct_r <= (pct_sat || pct_q > mtocc_pkg::PERCENT_SCALE) ? mtocc_pkg::PERCENT_SCALE : pct_q;
    end
    if (cmd.latch_xc) begin
      xc_r <= div_quo[mtocc_pkg::XC_W-1:0];
    end
    if (cmd.calc_idx) begin
      idx_r <= idx_full[mtocc_pkg::IDX_W-1:0];
    end
    if (cmd.emit) begin
      out_idx_r  <= idx_r;
      out_pct_r  <= pct_r;
      out_last_r <= row_last_r && flr_r;
    end
  end

  assign status.div_done  = div_done;
  assign status.tile_done = tile_done_r;
  assign status.out_busy  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_pct_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/mtocc_ctrl.sv =====
// Controller: sequences one mask word through position setup, column divide,
// count update and, on a tile close, percent, tile count and index steps.
// Depends on mtocc_pkg.
module mtocc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  mtocc_pkg::dp_status_t status,
  output mtocc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TC_GO,
    S_DIV_TC,
    S_READ,
    S_UPD,
    S_MUL,
    S_PCT_GO,
    S_DIV_PCT,
    S_DIV_XC,
    S_IDX,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_TC_GO;
        end
      end
      S_TC_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mtocc_pkg::DIV_TC;
        state_nxt     = S_DIV_TC;
      end
      S_DIV_TC: begin
        if (status.div_done) begin
          cmd.latch_tc = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.latch_cnt = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (status.tile_done) begin
          state_nxt = S_PCT_GO;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_PCT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mtocc_pkg::DIV_PCT;
        state_nxt     = S_DIV_PCT;
      end
      S_DIV_PCT: begin
        if (status.div_done) begin
          cmd.latch_pct = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = mtocc_pkg::DIV_XC;
          state_nxt     = S_DIV_XC;
        end
      end
      S_DIV_XC: begin
        if (status.div_done) begin
          cmd.latch_xc = 1'b1;
          state_nxt    = S_IDX;
        end
      end
      S_IDX: begin
        cmd.calc_idx = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

// ===== hw/rtl/mask_tile_occupancy_percent_core.sv =====
// Mask tile occupancy core: takes a binary mask one byte per word in raster
// order, cuts the frame into tile_width x tile_height tiles (edge tiles
// clipped) and, on the last pixel of each tile, sends the row-major tile
// index and the floored percentage of nonzero pixels; out_tlast marks the
// frame's final tile. One word is in work at a time: the next word is taken
// only after the 12-step column divide in the shared shift-subtract divider;
// a pixel that closes a tile adds a 7-step percent divide and a 13-step tile
// count divide, plus any wait of the previous result on out_tready.
// A finished result sits in an output register while the next word is taken.
// Configuration is to be written by the user only while the core is idle;
// the core itself does not enforce it.
// Depends on mtocc_pkg, mtocc_ctrl, mtocc_dp, mtocc_div and mtocc_ram.
module mask_tile_occupancy_percent_core #(
  parameter int MAX_TILE_COLUMNS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mtocc_pkg::MASK_W-1:0]      in_tdata,   // [7:0] mask_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mtocc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [19:0] tile_index, [26:20] percent
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [mtocc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mtocc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  mtocc_pkg::ctrl_cmd_t  cmd;
  mtocc_pkg::dp_status_t status;

  mtocc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mtocc_dp #(
    .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
